/* hdl/encoder_button_led_mode_controller_top_macros.svh */
// Assertion macros for the controller; ebl_core is the only module that uses them.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ENCODER_BUTTON_LED_MODE_CONTROLLER_TOP_MACROS_SVH
`define ENCODER_BUTTON_LED_MODE_CONTROLLER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

`define EBL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define EBL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`else

`define EBL_ASSERT(lbl, prop, msg)

`define EBL_ASSERT_IMP(lbl, ante, cons, msg)

`endif

`endif

/* hdl/ebl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ebl_pkg;

  localparam int POT_W       = 10;
  localparam int DEB_W       = 8;
  localparam int BLINK_W     = 16;
  localparam int DELAY_W     = BLINK_W + 1;
  localparam int PROD_W      = POT_W + BLINK_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int NUM_PLAIN   = 4;
  localparam int NUM_BUTTONS = 3;

  // Full-scale pot reading; the scaled span is divided by it.
  localparam int POT_FULL_SCALE = 1023;
  localparam int POT_SHIFT      = 10;

  localparam logic [DEB_W-1:0]   DEBOUNCE_RESET = 8'd25;
  localparam logic [BLINK_W-1:0] BASE_RESET     = 16'd250;
  localparam logic [BLINK_W-1:0] SPAN_RESET     = 16'd2550;
  localparam logic [BLINK_W-1:0] RGB_HALF_RESET = 16'd250;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE   = 2'd0,
    CFG_BASE_BLINK = 2'd1,
    CFG_BLINK_SPAN = 2'd2,
    CFG_RGB_HALF   = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    COL_NONE  = 3'd0,
    COL_RED   = 3'd1,
    COL_GREEN = 3'd2,
    COL_BLUE  = 3'd3,
    COL_WHITE = 3'd4
  } colour_e;

  typedef enum logic [1:0] {
    MODE_BLINK = 2'd0,
    MODE_OFF   = 2'd1,
    MODE_ON    = 2'd2
  } led_mode_e;

  typedef struct packed {
    logic ms_tick;
    logic enc_a;
    logic enc_b;
    logic enc_button;
    logic toggle_button;
    logic reset_button;
  } pins_t;

  typedef struct packed {
    pins_t              pins;
    logic [DELAY_W-1:0] delay;
  } step_t;

  typedef struct packed {
    logic       lamp_red;
    logic       lamp_green;
    logic       lamp_blue;
    logic       lamp_white;
    logic       mix_red;
    logic       mix_green;
    logic       mix_blue;
    logic [2:0] colour_choice;
    logic       is_active;
  } result_t;

  // Quadrature step for the transition from the previous to the current {A,B}.
  function automatic logic signed [1:0] quad_delta(input logic [1:0] prev,
                                                   input logic [1:0] cur);
    logic signed [1:0] d;
    case ({prev, cur})
      4'd1, 4'd7, 4'd8, 4'd14: d = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
      default: d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

/* hdl/ebl_debounce.sv */
`timescale 1ns / 1ps
`default_nettype none

module ebl_debounce #(
  parameter int STAMP_BITS = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic [STAMP_BITS-1:0]    ms_i,
  input  wire logic                     raw_i,
  input  wire logic [ebl_pkg::DEB_W-1:0] deb_i,
  output logic                          press_o
);
  import ebl_pkg::*;

  logic                  stable_q, last_q;
  logic [STAMP_BITS-1:0] stamp_q, stamp_d, elapsed;
  logic                  changed, accept;

  always_comb begin
    changed = raw_i != last_q;
    stamp_d = changed ? ms_i : stamp_q;
    elapsed = ms_i - stamp_d;
    accept  = (elapsed >= STAMP_BITS'(deb_i)) && (raw_i != stable_q);
    press_o = en_i && accept && !raw_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b1;
      last_q   <= 1'b1;
      stamp_q  <= '0;
    end else if (en_i) begin
      last_q  <= raw_i;
      stamp_q <= stamp_d;
      if (accept) begin
        stable_q <= raw_i;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/ebl_blink_delay.sv */
`timescale 1ns / 1ps
`default_nettype none

// Three-stage pipeline: base + pot * span / 1023. The division uses the
// series 1/1024 + 1/1024^2 + 1/1024^3, which lands at most one below the
// true quotient, followed by a single remainder correction.
module ebl_blink_delay (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_valid_i,
  output logic                              s_ready_o,
  input  wire ebl_pkg::pins_t               s_pins_i,
  input  wire logic [ebl_pkg::POT_W-1:0]    s_pot_i,
  input  wire logic [ebl_pkg::BLINK_W-1:0]  base_i,
  input  wire logic [ebl_pkg::BLINK_W-1:0]  span_i,
  output logic                              m_valid_o,
  input  wire logic                         m_ready_i,
  output ebl_pkg::step_t                    m_step_o
);
  import ebl_pkg::*;

  localparam int SUM_W = PROD_W + 1;

  logic                v1_q, v2_q, v3_q;
  logic                rdy1, rdy2, rdy3;
  pins_t               pins1_q, pins2_q, pins3_q;
  logic [PROD_W-1:0]   prod1_q, prod2_q, prod_d;
  logic [BLINK_W-1:0]  qest_q, qest_d;
  logic [SUM_W-1:0]    sum, rem;
  logic                corr;
  logic [DELAY_W-1:0]  delay_q, delay_d;

  always_comb begin
    rdy3      = !v3_q || m_ready_i;
    rdy2      = !v2_q || rdy3;
    rdy1      = !v1_q || rdy2;
    s_ready_o = rdy1;

    prod_d = PROD_W'(s_pot_i) * PROD_W'(span_i);

    sum    = SUM_W'(prod1_q) + SUM_W'(prod1_q >> POT_SHIFT)
           + SUM_W'(prod1_q >> (2 * POT_SHIFT));
    qest_d = BLINK_W'(sum >> POT_SHIFT);

    // Remainder of the estimate: prod - 1023 * qest, always below 2 * 1023.
    rem     = SUM_W'(prod2_q) - (SUM_W'(qest_q) << POT_SHIFT) + SUM_W'(qest_q);
    corr    = rem >= SUM_W'(POT_FULL_SCALE);
    delay_d = DELAY_W'(base_i) + DELAY_W'(qest_q) + DELAY_W'(corr);

    m_valid_o      = v3_q;
    m_step_o.pins  = pins3_q;
    m_step_o.delay = delay_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= s_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && s_valid_i) begin
      pins1_q <= s_pins_i;
      prod1_q <= prod_d;
    end
    if (rdy2 && v1_q) begin
      pins2_q <= pins1_q;
      prod2_q <= prod1_q;
      qest_q  <= qest_d;
    end
    if (rdy3 && v2_q) begin
      pins3_q <= pins2_q;
      delay_q <= delay_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/ebl_core.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "encoder_button_led_mode_controller_top_macros.svh"

module ebl_core #(
  parameter int STAMP_BITS = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_valid_i,
  output logic                              s_ready_o,
  input  wire ebl_pkg::step_t               s_step_i,
  input  wire logic [ebl_pkg::DEB_W-1:0]    deb_i,
  input  wire logic [ebl_pkg::BLINK_W-1:0]  rgb_half_i,
  output logic                              m_valid_o,
  input  wire logic                         m_ready_i,
  output ebl_pkg::result_t                  m_result_o
);
  import ebl_pkg::*;

  localparam int CMP_W = (STAMP_BITS > DELAY_W) ? STAMP_BITS : DELAY_W;
  localparam logic signed [3:0] STEP_LIMIT = 4'sd4;

  logic                  step, run;
  logic                  primed_q;
  logic [STAMP_BITS-1:0] ms_q, ms_n, ms_d;
  logic [2:0]            colour_q, colour_a, colour_d;
  logic                  active_q, active_d;
  logic [1:0]            mode_q [NUM_PLAIN];
  logic [1:0]            mode_d [NUM_PLAIN];
  logic                  plain_phase_q, plain_phase_d;
  logic                  rgb_phase_q, rgb_phase_d, rgb_phase_m;
  logic [STAMP_BITS-1:0] plain_stamp_q, plain_stamp_d;
  logic [STAMP_BITS-1:0] rgb_stamp_q, rgb_stamp_d, rgb_stamp_m;
  logic [STAMP_BITS-1:0] plain_elapsed, rgb_elapsed;
  logic [1:0]            prev_q, ab;
  logic signed [3:0]     steps_q, steps_d, steps_sum;
  logic signed [1:0]     delta;
  logic [NUM_BUTTONS-1:0] press;
  logic [NUM_BUTTONS-1:0] raw;
  logic                  act_tog, colour_ok;
  logic [1:0]            sel_idx;
  logic                  rgb_on;
  logic [2:0]            shown;
  logic                  out_valid_q;
  result_t               result_q, result_d;

  assign s_ready_o  = !out_valid_q || m_ready_i;
  assign step       = s_valid_i && s_ready_o;
  assign run        = step && primed_q;
  assign m_valid_o  = out_valid_q;
  assign m_result_o = result_q;
  assign raw = {s_step_i.pins.reset_button, s_step_i.pins.toggle_button,
                s_step_i.pins.enc_button};

  for (genvar k = 0; k < NUM_BUTTONS; k++) begin : g_btn
    ebl_debounce #(
      .STAMP_BITS(STAMP_BITS)
    ) u_debounce (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (run),
      .ms_i   (ms_n),
      .raw_i  (raw[k]),
      .deb_i  (deb_i),
      .press_o(press[k])
    );
  end

  always_comb begin
    ms_n = ms_q + STAMP_BITS'(s_step_i.pins.ms_tick);
    ab   = {s_step_i.pins.enc_a, s_step_i.pins.enc_b};

    // Encoder: accumulate quarter steps while idle, a full detent moves the colour.
    delta     = quad_delta(prev_q, ab);
    steps_sum = steps_q + 4'(delta);
    colour_a  = colour_q;
    steps_d   = steps_sum;
    if (active_q) begin
      steps_d = '0;
    end else if (steps_sum == STEP_LIMIT) begin
      steps_d  = '0;
      colour_a = (colour_q >= COL_WHITE) ? COL_NONE : colour_q + 3'd1;
    end else if (steps_sum == -STEP_LIMIT) begin
      steps_d = '0;
      if (colour_q > COL_WHITE) begin
        colour_a = COL_NONE;
      end else if (colour_q == COL_NONE) begin
        colour_a = COL_WHITE;
      end else begin
        colour_a = colour_q - 3'd1;
      end
    end

    act_tog   = press[0] && (colour_a != COL_NONE);
    colour_ok = (colour_a >= COL_RED) && (colour_a <= COL_WHITE);
    sel_idx   = 2'(colour_a - 3'd1);

    active_d = active_q;
    colour_d = colour_q;
    ms_d     = ms_q;
    for (int i = 0; i < NUM_PLAIN; i++) begin
      mode_d[i] = mode_q[i];
    end
    plain_phase_d = plain_phase_q;
    plain_stamp_d = plain_stamp_q;
    rgb_phase_d   = rgb_phase_q;
    rgb_stamp_d   = rgb_stamp_q;
    rgb_stamp_m   = rgb_stamp_q;
    rgb_phase_m   = rgb_phase_q;
    plain_elapsed = ms_n - plain_stamp_q;
    rgb_elapsed   = ms_n - rgb_stamp_q;

    if (run) begin
      ms_d     = ms_n;
      colour_d = colour_a;
      active_d = active_q ^ act_tog;

      // A reset press overrides a toggle press in the same step.
      if (active_d && colour_ok) begin
        if (press[2]) begin
          mode_d[sel_idx] = MODE_BLINK;
        end else if (press[1]) begin
          mode_d[sel_idx] = (mode_q[sel_idx] == MODE_ON) ? MODE_OFF : MODE_ON;
        end
      end

      if (CMP_W'(plain_elapsed) >= CMP_W'(s_step_i.delay)) begin
        plain_stamp_d = ms_n;
        plain_phase_d = !plain_phase_q;
      end

      if (act_tog) begin
        rgb_stamp_m = ms_n;
        rgb_phase_m = 1'b1;
      end
      rgb_elapsed = ms_n - rgb_stamp_m;
      rgb_stamp_d = rgb_stamp_m;
      rgb_phase_d = rgb_phase_m;
      if (!active_d || colour_a == COL_NONE) begin
        rgb_phase_d = 1'b0;
      end else if (CMP_W'(rgb_elapsed) >= CMP_W'(rgb_half_i)) begin
        rgb_stamp_d = ms_n;
        rgb_phase_d = !rgb_phase_m;
      end
    end

    rgb_on = active_d ? rgb_phase_d : 1'b1;
    shown  = rgb_on ? colour_d : COL_NONE;

    result_d.lamp_red   = (mode_d[0] == MODE_BLINK) ? plain_phase_d : (mode_d[0] == MODE_ON);
    result_d.lamp_green = (mode_d[1] == MODE_BLINK) ? plain_phase_d : (mode_d[1] == MODE_ON);
    result_d.lamp_blue  = (mode_d[2] == MODE_BLINK) ? plain_phase_d : (mode_d[2] == MODE_ON);
    result_d.lamp_white = (mode_d[3] == MODE_BLINK) ? plain_phase_d : (mode_d[3] == MODE_ON);
    result_d.mix_red    = (shown == COL_RED) || (shown == COL_WHITE);
    result_d.mix_green  = (shown == COL_GREEN) || (shown == COL_WHITE);
    result_d.mix_blue   = (shown == COL_BLUE) || (shown == COL_WHITE);
    result_d.colour_choice = colour_d;
    result_d.is_active     = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q      <= 1'b0;
      prev_q        <= '0;
      steps_q       <= '0;
      ms_q          <= '0;
      colour_q      <= COL_NONE;
      active_q      <= 1'b0;
      for (int i = 0; i < NUM_PLAIN; i++) begin
        mode_q[i] <= MODE_BLINK;
      end
      plain_phase_q <= 1'b0;
      plain_stamp_q <= '0;
      rgb_phase_q   <= 1'b0;
      rgb_stamp_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (s_ready_o) begin
        out_valid_q <= s_valid_i;
      end
      if (step) begin
        primed_q <= 1'b1;
        prev_q   <= ab;
      end
      if (run) begin
        steps_q       <= steps_d;
        ms_q          <= ms_d;
        colour_q      <= colour_d;
        active_q      <= active_d;
        for (int i = 0; i < NUM_PLAIN; i++) begin
          mode_q[i] <= mode_d[i];
        end
        plain_phase_q <= plain_phase_d;
        plain_stamp_q <= plain_stamp_d;
        rgb_phase_q   <= rgb_phase_d;
        rgb_stamp_q   <= rgb_stamp_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= result_d;
    end
  end

  `EBL_ASSERT(a_colour_range, colour_q <= COL_WHITE, "colour selection out of range")
  `EBL_ASSERT(a_steps_range, (steps_q > -STEP_LIMIT) && (steps_q < STEP_LIMIT), "encoder steps overrun")
  `EBL_ASSERT_IMP(a_active_colour, active_q, colour_q != COL_NONE, "active without a colour")
  `EBL_ASSERT_IMP(a_rgb_idle, !active_q, !rgb_phase_q, "RGB phase set while inactive")
  `EBL_ASSERT_IMP(a_unprimed, !primed_q, ms_q == '0, "time advanced before first sample")

endmodule

`default_nettype wire

/* hdl/encoder_button_led_mode_controller_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Encoder, button and LED mode controller. Each input transfer is one sample
// of the raw pins plus a millisecond tick; each sample produces exactly one
// output transfer with the LED drives, the selected colour and the active flag.
// One sample is accepted per clock cycle while the output is not stalled. On
// its way to the output, the 10x16 pot-times-span product is registered with
// the sample, the next stage forms a quotient estimate for the divide by
// 1023, the third corrects it and adds the base half-period, and the state
// update then loads the result register. Up to four samples are in flight;
// a stalled output holds the whole pipeline. Configuration writes take effect
// on the next sample and must only be issued while idle.
module encoder_button_led_mode_controller_top #(
  parameter int STAMP_BITS = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // tdata: ms_tick, enc_a, enc_b, enc_button, toggle_button, reset_button,
  //        pot_level[9:0]
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [ebl_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // tdata: plain red, green, blue and white LEDs, RGB red, green and blue
  //        channels, colour_choice[2:0], is_active, zero padding
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [ebl_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  input  wire logic                            cfg_we_i,
  input  wire logic [ebl_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [ebl_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import ebl_pkg::*;

  logic [DEB_W-1:0]   deb_q;
  logic [BLINK_W-1:0] base_q, span_q, rgb_half_q;
  pins_t              pins;
  logic               mid_valid, mid_ready;
  step_t              mid_step;
  result_t            result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q      <= DEBOUNCE_RESET;
      base_q     <= BASE_RESET;
      span_q     <= SPAN_RESET;
      rgb_half_q <= RGB_HALF_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_DEBOUNCE:   deb_q      <= DEB_W'(cfg_data_i);
        CFG_BASE_BLINK: base_q     <= cfg_data_i;
        CFG_BLINK_SPAN: span_q     <= cfg_data_i;
        CFG_RGB_HALF:   rgb_half_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The tick sits in bit 0 and is the first, most significant struct member.
  assign pins = {s_axis_tdata[0], s_axis_tdata[1], s_axis_tdata[2], s_axis_tdata[3],
                 s_axis_tdata[4], s_axis_tdata[5]};

  ebl_blink_delay u_delay (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_ready_o(s_axis_tready),
    .s_pins_i (pins),
    .s_pot_i  (s_axis_tdata[15:6]),
    .base_i   (base_q),
    .span_i   (span_q),
    .m_valid_o(mid_valid),
    .m_ready_i(mid_ready),
    .m_step_o (mid_step)
  );

  ebl_core #(
    .STAMP_BITS(STAMP_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (mid_valid),
    .s_ready_o (mid_ready),
    .s_step_i  (mid_step),
    .deb_i     (deb_q),
    .rgb_half_i(rgb_half_q),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_result_o(result)
  );

  assign m_axis_tdata = {5'b0, result.is_active, result.colour_choice,
                         result.mix_blue, result.mix_green, result.mix_red,
                         result.lamp_white, result.lamp_blue, result.lamp_green,
                         result.lamp_red};

endmodule

`default_nettype wire
